FILE: design/ppmfd_pkg.sv
`default_nettype none
package ppmfd_pkg;

  // Number of channel slots in one frame (1 to 16).
  localparam int CHANNELS = 8;

  localparam int SLOT_W  = 5;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 32;
  localparam int WIDTH_W = 16;
  localparam int DMAX_W  = 17;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [SLOT_W-1:0] SLOT_IDLE = SLOT_W'(CHANNELS);
  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHANNELS - 1);

  localparam logic [VALUE_W-1:0] SYNC_MIN_RST = 32'd3000;
  localparam logic [VALUE_W-1:0] SYNC_MAX_RST = 32'd30000;
  localparam logic [WIDTH_W-1:0] DATA_MIN_RST = 16'd800;
  localparam logic [DMAX_W-1:0]  DATA_MAX_RST = 17'd2200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_MIN = 2'd0,
    REG_SYNC_MAX = 2'd1,
    REG_DATA_MIN = 2'd2,
    REG_DATA_MAX = 2'd3
  } cfg_reg_t;

  // Control from the sequencer to the row of width cells.
  typedef struct packed {
    logic               shift;
    logic [WIDTH_W-1:0] width;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/ppmfd_in_if.sv
`default_nettype none
interface ppmfd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [ppmfd_pkg::VALUE_W-1:0]   value;
  logic                            rssi_ok;

  modport source (output valid, output kind, output value, output rssi_ok, input ready);
  modport sink   (input valid, input kind, input value, input rssi_ok, output ready);
endinterface
`default_nettype wire

FILE: design/ppmfd_out_if.sv
`default_nettype none
interface ppmfd_out_if;
  logic                            valid;
  logic                            ready;
  logic [ppmfd_pkg::CHAN_W-1:0]    channel;
  logic [ppmfd_pkg::WIDTH_W-1:0]   width;
  logic                            last;

  modport source (output valid, output channel, output width, output last, input ready);
  modport sink   (input valid, input channel, input width, input last, output ready);
endinterface
`default_nettype wire

FILE: design/ppmfd_cell.sv
`default_nettype none
module ppmfd_cell (
  input  wire logic                          clk,
  input  wire logic                          shift,
  input  wire logic [ppmfd_pkg::WIDTH_W-1:0] d,
  output logic      [ppmfd_pkg::WIDTH_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

FILE: design/ppmfd_ctrl.sv
`default_nettype none
module ppmfd_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  ppmfd_in_if.sink                               in_item,
  ppmfd_out_if.source                            out_item,
  input  wire logic                              cfg_we,
  input  wire logic [ppmfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppmfd_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic [ppmfd_pkg::WIDTH_W-1:0]     head_width,
  output ppmfd_pkg::cell_ctrl_t                  cell_ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                          state, state_next;
  logic [ppmfd_pkg::SLOT_W-1:0]    slot_index, slot_index_next;
  logic [ppmfd_pkg::VALUE_W-1:0]   prev_edge_time;
  logic                            frame_complete, frame_complete_next;
  logic [ppmfd_pkg::CHAN_W-1:0]    count, count_next;

  logic [ppmfd_pkg::VALUE_W-1:0]   sync_min_ticks;
  logic [ppmfd_pkg::VALUE_W-1:0]   sync_max_ticks;
  logic [ppmfd_pkg::WIDTH_W-1:0]   data_min_ticks;
  logic [ppmfd_pkg::DMAX_W-1:0]    data_max_ticks;

  logic [ppmfd_pkg::VALUE_W-1:0]   w;
  logic                            accept;
  logic                            out_xfer;
  logic                            waiting;
  logic                            sync_ok;
  logic                            data_ok;
  logic                            release_frame;
  logic                            store;

  assign in_item.ready = (state == ST_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign out_xfer      = out_item.valid && out_item.ready;

  assign w = in_item.kind ? in_item.value : (in_item.value - prev_edge_time);

  assign waiting = (slot_index >= ppmfd_pkg::SLOT_IDLE);
  assign sync_ok = (w > sync_min_ticks) && (w < sync_max_ticks);
  assign data_ok = (w > {16'd0, data_min_ticks}) && (w < {15'd0, data_max_ticks});

  assign release_frame = accept && waiting && sync_ok && frame_complete && in_item.rssi_ok;
  assign store         = accept && !waiting && data_ok;

  // Widths enter at the tail of the row; a release drains the row from the head.
  assign cell_ctrl.shift = store || out_xfer;
  assign cell_ctrl.width = w[ppmfd_pkg::WIDTH_W-1:0];

  assign out_item.valid   = (state == ST_EMIT);
  assign out_item.channel = count;
  assign out_item.width   = head_width;
  assign out_item.last    = (count == ppmfd_pkg::CHAN_LAST);

  always_comb begin
    slot_index_next     = slot_index;
    frame_complete_next = frame_complete;
    if (accept) begin
      if (waiting) begin
        if (sync_ok) begin
          slot_index_next = '0;
          if (release_frame) begin
            frame_complete_next = 1'b0;
          end
        end else begin
          slot_index_next     = ppmfd_pkg::SLOT_IDLE;
          frame_complete_next = 1'b0;
        end
      end else if (data_ok) begin
        slot_index_next = slot_index + 1'b1;
        if (slot_index_next == ppmfd_pkg::SLOT_IDLE) begin
          frame_complete_next = 1'b1;
        end
      end else begin
        slot_index_next     = ppmfd_pkg::SLOT_IDLE;
        frame_complete_next = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      ST_IDLE: begin
        if (release_frame) begin
          state_next = ST_EMIT;
          count_next = '0;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (out_item.last) begin
            state_next = ST_IDLE;
            count_next = '0;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      slot_index     <= ppmfd_pkg::SLOT_IDLE;
      frame_complete <= 1'b0;
      prev_edge_time <= '0;
    end else begin
      state          <= state_next;
      count          <= count_next;
      slot_index     <= slot_index_next;
      frame_complete <= frame_complete_next;
      if (accept && !in_item.kind) begin
        prev_edge_time <= in_item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min_ticks <= ppmfd_pkg::SYNC_MIN_RST;
      sync_max_ticks <= ppmfd_pkg::SYNC_MAX_RST;
      data_min_ticks <= ppmfd_pkg::DATA_MIN_RST;
      data_max_ticks <= ppmfd_pkg::DATA_MAX_RST;
    end else if (cfg_we) begin
      unique case (ppmfd_pkg::cfg_reg_t'(cfg_index))
        ppmfd_pkg::REG_SYNC_MIN: sync_min_ticks <= cfg_data;
        ppmfd_pkg::REG_SYNC_MAX: sync_max_ticks <= cfg_data;
        ppmfd_pkg::REG_DATA_MIN: data_min_ticks <= cfg_data[ppmfd_pkg::WIDTH_W-1:0];
        ppmfd_pkg::REG_DATA_MAX: data_max_ticks <= cfg_data[ppmfd_pkg::DMAX_W-1:0];
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> !in_item.ready)
    else $error("input accepted while a frame is being released");

  a_release_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    release_frame |=> (out_item.valid && (out_item.channel == '0)))
    else $error("frame release did not start at channel zero");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && out_item.last) |=> (in_item.ready && !out_item.valid))
    else $error("decoder did not return to idle after the last channel");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    slot_index <= ppmfd_pkg::SLOT_IDLE)
    else $error("slot index beyond channel count");

  a_release_needs_full_frame: assert property (@(posedge clk) disable iff (rst)
    release_frame |-> (frame_complete && waiting))
    else $error("frame released without a complete set of channels");
`endif

endmodule
`default_nettype wire

FILE: design/ppm_frame_decoder_unit.sv
`default_nettype none
// PPM frame decoder.
// in_item carries one pulse edge timestamp (kind 0) or one ready width (kind 1)
// with the rssi_ok flag; a transfer takes place when valid and ready are high.
// out_item carries the released channels: channel index, width and a last mark.
// The cfg port writes the window limits (sync min, sync max, data min, data max)
// by index; write only while no frame is being released. A sync that releases
// a stored frame makes the outputs valid on the next cycle and then holds the
// input off while the row of width cells drains from its head, one channel per
// output transfer. When the receiver holds ready low, the current channel stays
// on the port and nothing moves. Reset restores the default windows, clears the
// last timestamp and puts the decoder in the wait-for-sync state; stored widths
// are not cleared, since a release only follows a full set of fresh widths.
module ppm_frame_decoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  ppmfd_in_if.sink                               in_item,
  ppmfd_out_if.source                            out_item,
  input  wire logic                              cfg_we,
  input  wire logic [ppmfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppmfd_pkg::CFG_W-1:0]       cfg_data
);

  ppmfd_pkg::cell_ctrl_t            cell_ctrl;
  logic [ppmfd_pkg::WIDTH_W-1:0]    cell_q [ppmfd_pkg::CHANNELS];

  ppmfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_width (cell_q[0]),
    .cell_ctrl  (cell_ctrl)
  );

  for (genvar i = 0; i < ppmfd_pkg::CHANNELS; i++) begin : g_cell
    if (i == ppmfd_pkg::CHANNELS - 1) begin : g_tail
      ppmfd_cell u_cell (
        .clk   (clk),
        .shift (cell_ctrl.shift),
        .d     (cell_ctrl.width),
        .q     (cell_q[i])
      );
    end else begin : g_body
      ppmfd_cell u_cell (
        .clk   (clk),
        .shift (cell_ctrl.shift),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

endmodule
`default_nettype wire

FILE: bench/ppm_frame_decoder_checker.sv
`default_nettype none
module ppm_frame_decoder_checker
  import ppmfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  ppmfd_in_if                       in_mon,
  ppmfd_out_if                      out_mon,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct {
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } chan_result_t;

  chan_result_t       released_q[$];

  logic [VALUE_W-1:0] sync_lo;
  logic [VALUE_W-1:0] sync_hi;
  logic [WIDTH_W-1:0] data_lo;
  logic [DMAX_W-1:0]  data_hi;

  logic [SLOT_W-1:0]  slot;
  logic [VALUE_W-1:0] last_stamp;
  logic               full_set;
  logic [WIDTH_W-1:0] widths [CHANNELS];

  // Applies one measured width to the frame state; a sync after a full set of
  // channels with good signal quality queues the whole frame for release.
  task automatic decode_width(input logic [VALUE_W-1:0] w, input logic rssi);
    chan_result_t res;
    if (slot >= SLOT_IDLE) begin
      if (w > sync_lo && w < sync_hi) begin
        if (full_set && rssi) begin
          for (int k = 0; k < CHANNELS; k++) begin
            res.channel = CHAN_W'(k);
            res.width   = widths[k];
            res.last    = (k == CHANNELS - 1);
            released_q.push_back(res);
          end
          full_set = 1'b0;
        end
        slot = '0;
      end else begin
        slot     = SLOT_IDLE;
        full_set = 1'b0;
      end
    end else begin
      if (w > VALUE_W'(data_lo) && w < VALUE_W'(data_hi)) begin
        widths[slot] = w[WIDTH_W-1:0];
        slot = slot + 1'b1;
        if (slot == SLOT_IDLE)
          full_set = 1'b1;
      end else begin
        slot     = SLOT_IDLE;
        full_set = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    chan_result_t       want;
    logic [VALUE_W-1:0] w;
    if (rst) begin
      sync_lo     = SYNC_MIN_RST;
      sync_hi     = SYNC_MAX_RST;
      data_lo     = DATA_MIN_RST;
      data_hi     = DATA_MAX_RST;
      slot        = SLOT_IDLE;
      last_stamp  = '0;
      full_set    = 1'b0;
      mismatches  = 0;
      released_q.delete();
    end else begin
      // Results are compared before the input transfer of the same edge is
      // applied, since a release only shows on the port in the following cycle.
      if (out_mon.valid && out_mon.ready) begin
        if (released_q.size() == 0) begin
          $error("unexpected result: channel %0d width %0d last %0b",
                 out_mon.channel, out_mon.width, out_mon.last);
          mismatches++;
        end else begin
          want = released_q.pop_front();
          if (out_mon.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, out_mon.channel);
            mismatches++;
          end
          if (out_mon.width !== want.width) begin
            $error("width: expected %0d, got %0d", want.width, out_mon.width);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_mon.last);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SYNC_MIN: sync_lo = cfg_data[VALUE_W-1:0];
          REG_SYNC_MAX: sync_hi = cfg_data[VALUE_W-1:0];
          REG_DATA_MIN: data_lo = cfg_data[WIDTH_W-1:0];
          REG_DATA_MAX: data_hi = cfg_data[DMAX_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == 1'b0) begin
          w          = in_mon.value - last_stamp;
          last_stamp = in_mon.value;
        end else begin
          w = in_mon.value;
        end
        decode_width(w, in_mon.rssi_ok);
      end
    end
    outstanding = released_q.size();
  end

endmodule
`default_nettype wire

FILE: bench/ppm_frame_decoder_unit_tb.sv
`default_nettype none
module ppm_frame_decoder_unit_tb;
  import ppmfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTINGS_N  = 6;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;

  int                   tx_gap_pct;
  int                   rx_stall_pct;
  int                   items_sent;

  // Stimulus-side copies of what has been sent, used only to shape widths.
  logic [VALUE_W-1:0]   stamp_now;
  logic [VALUE_W-1:0]   win_sync_lo;
  logic [VALUE_W-1:0]   win_sync_hi;
  logic [VALUE_W-1:0]   win_data_lo;
  logic [VALUE_W-1:0]   win_data_hi;

  ppmfd_in_if  in_item();
  ppmfd_out_if out_item();

  ppm_frame_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppm_frame_decoder_checker frame_check (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_item),
    .out_mon     (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_item.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ppm_frame_decoder_unit_tb failed");
    $finish;
  end

  // One input transfer, with random idle cycles in front of it.
  task automatic send_raw(input logic k, input logic [VALUE_W-1:0] v, input logic r);
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_item.valid <= 1'b0;
      @(negedge clk);
    end
    in_item.valid   <= 1'b1;
    in_item.kind    <= k;
    in_item.value   <= v;
    in_item.rssi_ok <= r;
    if (k == 1'b0)
      stamp_now = v;
    items_sent++;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
  endtask

  // Sends a width either directly or as the next edge timestamp.
  task automatic send_width(input logic [VALUE_W-1:0] w, input logic r);
    if ($urandom_range(1))
      send_raw(1'b1, w, r);
    else
      send_raw(1'b0, stamp_now + w, r);
  endtask

  // A width strictly inside the window, or the lower limit if it is empty.
  function automatic logic [VALUE_W-1:0] pick_inside(input longint lo, input longint hi);
    if (hi - lo < 2)
      return lo[VALUE_W-1:0];
    case ($urandom_range(5))
      0:       return 32'(lo + 1);
      1:       return 32'(hi - 1);
      default: return $urandom_range(32'(hi - 1), 32'(lo + 1));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_outside(input longint lo, input longint hi);
    case ($urandom_range(4))
      0:       return lo[VALUE_W-1:0];
      1:       return hi[VALUE_W-1:0];
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Sync then a full set of channels; now and then one channel is spoilt.
  task automatic run_frame();
    int spoilt;
    spoilt = ($urandom_range(9) == 0) ? $urandom_range(CHANNELS - 1) : -1;
    send_width(pick_inside(64'(win_sync_lo), 64'(win_sync_hi)), ($urandom_range(9) < 8));
    for (int s = 0; s < CHANNELS; s++) begin
      if (s == spoilt)
        send_width(pick_outside(64'(win_data_lo), 64'(win_data_hi)),
                   1'($urandom_range(1)));
      else
        send_width(pick_inside(64'(win_data_lo), 64'(win_data_hi)),
                   1'($urandom_range(1)));
    end
  endtask

  task automatic send_noise();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(5))
      0:       v = win_sync_lo;
      1:       v = win_sync_hi;
      2:       v = win_data_lo;
      3:       v = win_data_hi;
      default: v = $urandom();
    endcase
    send_raw(1'($urandom_range(1)), v, 1'($urandom_range(1)));
  endtask

  // Waits until the block is idle, then writes all four window limits.
  // Unused upper bits of the narrow registers carry junk on purpose.
  task automatic write_windows(input logic [31:0] s_lo, input logic [31:0] s_hi,
                               input logic [15:0] d_lo, input logic [16:0] d_hi);
    @(negedge clk);
    in_item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_MIN;
    cfg_data  <= s_lo;
    @(negedge clk);
    cfg_index <= REG_SYNC_MAX;
    cfg_data  <= s_hi;
    @(negedge clk);
    cfg_index <= REG_DATA_MIN;
    cfg_data  <= {16'($urandom()), d_lo};
    @(negedge clk);
    cfg_index <= REG_DATA_MAX;
    cfg_data  <= {15'($urandom()), d_hi};
    @(negedge clk);
    cfg_we    <= 1'b0;
    win_sync_lo = s_lo;
    win_sync_hi = s_hi;
    win_data_lo = 32'(d_lo);
    win_data_hi = 32'(d_hi);
  endtask

  task automatic apply_setting(input int n);
    case (n)
      0:       write_windows(32'd3000, 32'd30000, 16'd800, 17'd2200);
      1:       write_windows(32'd0, 32'hFFFF_FFFF, 16'd0, 17'h1_0000);
      2:       write_windows(32'd100, 32'd101, 16'd50, 17'd60);
      3:       write_windows(32'd40000, 32'd50000, 16'd1000, 17'd1000);
      4:       write_windows(32'd10, 32'hFFFF_FFFF, 16'hFFFE, 17'h1_0000);
      default: write_windows(32'd5, 32'd20, 16'd0, 17'd3);
    endcase
  endtask

  initial begin
    int budget [SETTINGS_N];
    int mark;
    budget = '{27, 22, 6, 9, 18, 17};
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_SYNC_MIN;
    cfg_data        = '0;
    in_item.valid   = 1'b0;
    in_item.kind    = 1'b0;
    in_item.value   = '0;
    in_item.rssi_ok = 1'b0;
    out_item.ready  = 1'b0;
    tx_gap_pct      = 34;
    rx_stall_pct    = 55;
    items_sent      = 0;
    stamp_now       = '0;
    win_sync_lo     = SYNC_MIN_RST;
    win_sync_hi     = SYNC_MAX_RST;
    win_data_lo     = 32'(DATA_MIN_RST);
    win_data_hi     = 32'(DATA_MAX_RST);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset windows.
    send_raw(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_raw(1'b0, 32'hFFFF_FFF0, 1'b0);
    // The timestamp wraps round zero and yields a valid sync width.
    send_raw(1'b0, 32'h0000_0BC0, 1'b1);
    send_width(32'd801, 1'b1);
    send_width(32'd2199, 1'b0);
    send_width(32'd1000, 1'b1);
    send_width(32'd2000, 1'b1);
    send_width(32'd1234, 1'b0);
    send_width(32'd1800, 1'b1);
    send_width(32'd900, 1'b1);
    send_width(32'd2100, 1'b1);
    send_width(32'd29999, 1'b1);
    for (int s = 0; s < CHANNELS; s++)
      send_width(32'd801 + 32'(s * 150), 1'b1);
    // Sync with poor signal quality starts a frame but releases nothing.
    send_width(32'd3001, 1'b0);
    send_width(32'd2200, 1'b1);
    send_width(32'd3000, 1'b1);
    send_width(32'd30000, 1'b1);
    send_raw(1'b1, 32'd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct   = 34;
          rx_stall_pct = 55;
        end
        1: begin
          tx_gap_pct   = 55;
          rx_stall_pct = 34;
        end
        default: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < SETTINGS_N; n++) begin
        apply_setting(n);
        mark = items_sent;
        while (items_sent - mark < budget[n]) begin
          if ($urandom_range(3) != 0)
            run_frame();
          else
            send_noise();
        end
      end
    end

    @(negedge clk);
    in_item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CHANNELS * 4) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ppm_frame_decoder_unit_tb passed");
    else
      $display("ppm_frame_decoder_unit_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
